FILE: src/saq_pkg.sv
`timescale 1ns / 1ps
// saq_pkg: shared widths and pipeline depth of the shortest-arc quaternion block
package saq_pkg;

  localparam int OUT_FRAC_BITS_DEF = 30;
  localparam int IN_W = 32;
  localparam int Q_W = 32;
  localparam int NORM_IN_W = 33;
  localparam int MAG_W = 32;
  localparam int SQRT_STEPS = 32;

  // register stages of one normalizer, input to output register
  function automatic int norm_lat(input int ofb);
    return ofb + 40;
  endfunction

endpackage

FILE: src/saq_norm.sv
`timescale 1ns / 1ps
// saq_norm: pipelined fixed-point normalizer for one 3-vector
module saq_norm #(
  parameter int OutFracBits = saq_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [saq_pkg::NORM_IN_W-1:0] c_i [3],
  output logic                                 valid_o,
  output logic                                 nz_o,
  output logic signed [OutFracBits+1:0]        o_o [3]
);
  import saq_pkg::*;

  localparam int OW = OutFracBits + 2;
  localparam int DIVS = OutFracBits + 1;
  localparam int NW = MAG_W + OutFracBits;
  localparam int SQW = 2 * MAG_W;
  localparam int NST = norm_lat(OutFracBits);

  logic [NST-1:0] vld_q;

  // stage 1: magnitudes
  logic [MAG_W-1:0] a1_q [3];
  logic [2:0]       neg1_q;
  // stage 2: largest magnitude
  logic [MAG_W-1:0] a2_q [3];
  logic [MAG_W-1:0] m2_q;
  logic [2:0]       neg2_q;
  logic             z2_q;
  // stage 3: shifted magnitudes
  logic [MAG_W-1:0] a3_d [3];
  logic [MAG_W-1:0] a3_q [3];
  logic [2:0]       neg3_q;
  logic             z3_q;
  // stage 4: squares
  logic [SQW-1:0]   sq4_q [3];
  logic [MAG_W-1:0] a4_q [3];
  logic [2:0]       neg4_q;
  logic             z4_q;
  // square root steps
  logic [SQW-1:0]   sn_q [SQRT_STEPS];
  logic [SQW-1:0]   sr_q [SQRT_STEPS+1];
  logic [MAG_W-1:0] sa_q [SQRT_STEPS+1][3];
  logic [2:0]       sneg_q [SQRT_STEPS+1];
  logic             sz_q [SQRT_STEPS+1];
  // divider steps: remaining dividend bits shift out, quotient bits shift in
  logic [MAG_W-1:0] dr_q [DIVS][3];
  logic [DIVS-1:0]  dlo_q [DIVS+1][3];
  logic [MAG_W-1:0] dd_q [DIVS];
  logic [2:0]       dneg_q [DIVS+1];
  logic             dz_q [DIVS+1];
  // output
  logic signed [OW-1:0] o_q [3];
  logic                 oz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= c_i[i][NORM_IN_W-1];
        a1_q[i]   <= c_i[i][NORM_IN_W-1] ? MAG_W'(-c_i[i]) : MAG_W'(c_i[i]);
      end
    end
  end

  logic [MAG_W-1:0] m01;
  logic [MAG_W-1:0] m012;
  assign m01  = (a1_q[0] > a1_q[1]) ? a1_q[0] : a1_q[1];
  assign m012 = (m01 > a1_q[2]) ? m01 : a1_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q   <= a1_q;
      m2_q   <= m012;
      neg2_q <= neg1_q;
      z2_q   <= (m012 == '0);
    end
  end

  // shift all three together until the largest reaches bit 30
  always_comb begin
    logic [MAG_W-1:0] m_s;
    m_s  = m2_q;
    a3_d = a2_q;
    for (int k = 4; k >= 0; k--) begin
      if (m_s < (MAG_W'(1) << (MAG_W - 1 - (1 << k)))) begin
        m_s = m_s << (1 << k);
        for (int i = 0; i < 3; i++) begin
          a3_d[i] = a3_d[i] << (1 << k);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_q   <= a3_d;
      neg3_q <= neg2_q;
      z3_q   <= z2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= a3_q[i] * a3_q[i];
      end
      a4_q   <= a3_q;
      neg4_q <= neg3_q;
      z4_q   <= z3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q[0]   <= sq4_q[0] + sq4_q[1] + sq4_q[2];
      sr_q[0]   <= '0;
      sa_q[0]   <= a4_q;
      sneg_q[0] <= neg4_q;
      sz_q[0]   <= z4_q;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQW-1:0] RootBit = SQW'(1) << (SQW - 2 - 2 * k);
    logic [SQW-1:0] trial;
    logic           take;
    assign trial = sr_q[k] + RootBit;
    assign take  = (sn_q[k] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[k+1]   <= take ? ((sr_q[k] >> 1) + RootBit) : (sr_q[k] >> 1);
        sa_q[k+1]   <= sa_q[k];
        sneg_q[k+1] <= sneg_q[k];
        sz_q[k+1]   <= sz_q[k];
      end
    end

    if (k < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sn_q[k+1] <= take ? (sn_q[k] - trial) : sn_q[k];
        end
      end
    end
  end

  // divider setup: dividend = (a << frac) + len/2
  logic [MAG_W-1:0] len;
  logic [NW-1:0]    num [3];
  assign len = sr_q[SQRT_STEPS][MAG_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {sa_q[SQRT_STEPS][i], {OutFracBits{1'b0}}} + NW'(len >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i]  <= MAG_W'(num[i] >> DIVS);
        dlo_q[0][i] <= num[i][DIVS-1:0];
      end
      dd_q[0]   <= len;
      dneg_q[0] <= sneg_q[SQRT_STEPS];
      dz_q[0]   <= sz_q[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < DIVS; j++) begin : g_div
    logic [MAG_W:0]   t   [3];
    logic [MAG_W:0]   rn  [3];
    logic [2:0]       ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dr_q[j][i], dlo_q[j][i][DIVS-1]};
        ge[i] = (t[i] >= {1'b0, dd_q[j]});
        rn[i] = ge[i] ? (t[i] - {1'b0, dd_q[j]}) : t[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dlo_q[j+1][i] <= {dlo_q[j][i][DIVS-2:0], ge[i]};
        end
        dneg_q[j+1] <= dneg_q[j];
        dz_q[j+1]   <= dz_q[j];
      end
    end

    if (j < DIVS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          for (int i = 0; i < 3; i++) begin
            dr_q[j+1][i] <= rn[i][MAG_W-1:0];
          end
          dd_q[j+1] <= dd_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dz_q[DIVS]) begin
          o_q[i] <= '0;
        end else if (dneg_q[DIVS][i]) begin
          o_q[i] <= -signed'({1'b0, dlo_q[DIVS][i]});
        end else begin
          o_q[i] <= signed'({1'b0, dlo_q[DIVS][i]});
        end
      end
      oz_q <= dz_q[DIVS];
    end
  end

  assign valid_o = vld_q[NST-1];
  assign nz_o    = !oz_q;
  assign o_o     = o_q;

endmodule

FILE: src/shortest_arc_quaternion.sv
`timescale 1ns / 1ps
// throughput: one beat per cycle while the output register is empty or being taken; depth
// comes from two chained normalizers, each a 32-step root pipeline followed by an
// OutFracBits+1 step divider pipeline
// the whole pipeline advances when the output register is empty or being taken
// reset clears the valid bits only, payload registers are not reset
module shortest_arc_quaternion #(
  parameter int OutFracBits = saq_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [saq_pkg::IN_W-1:0]   first_x_i,
  input  logic signed [saq_pkg::IN_W-1:0]   first_y_i,
  input  logic signed [saq_pkg::IN_W-1:0]   first_z_i,
  input  logic signed [saq_pkg::IN_W-1:0]   second_x_i,
  input  logic signed [saq_pkg::IN_W-1:0]   second_y_i,
  input  logic signed [saq_pkg::IN_W-1:0]   second_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [saq_pkg::Q_W-1:0]    quat_w_o,
  output logic signed [saq_pkg::Q_W-1:0]    quat_x_o,
  output logic signed [saq_pkg::Q_W-1:0]    quat_y_o,
  output logic signed [saq_pkg::Q_W-1:0]    quat_z_o,
  output logic                              opposite_case_o,
  output logic                              zero_input_o
);
  import saq_pkg::*;

  localparam int OW = OutFracBits + 2;
  localparam int PW = 2 * OW;
  localparam int SW = PW + 2;
  localparam int DW = 3 * OW + 2;
  localparam int LAT = norm_lat(OutFracBits);
  localparam logic [SW-1:0] HalfLsb = SW'(1) << (OutFracBits - 1);
  localparam logic signed [SW-1:0] QMax = SW'(64'h7fff_ffff);
  localparam logic signed [SW-1:0] QMin = ~QMax;

  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_e;

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // first normalization of both vectors
  logic signed [NORM_IN_W-1:0] cu [3];
  logic signed [NORM_IN_W-1:0] cv [3];
  logic signed [OW-1:0]        u   [3];
  logic signed [OW-1:0]        v   [3];
  logic                        uv_valid;
  logic                        nz_u;
  logic                        nz_v;

  assign cu[0] = NORM_IN_W'(first_x_i);
  assign cu[1] = NORM_IN_W'(first_y_i);
  assign cu[2] = NORM_IN_W'(first_z_i);
  assign cv[0] = NORM_IN_W'(second_x_i);
  assign cv[1] = NORM_IN_W'(second_y_i);
  assign cv[2] = NORM_IN_W'(second_z_i);

  saq_norm #(.OutFracBits(OutFracBits)) u_norm_u (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .c_i(cu),
    .valid_o(uv_valid), .nz_o(nz_u), .o_o(u)
  );

  saq_norm #(.OutFracBits(OutFracBits)) u_norm_v (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .c_i(cv),
    .valid_o(), .nz_o(nz_v), .o_o(v)
  );

  // sum, opposite test and fallback axis
  logic signed [OW:0]   s_d [3];
  logic signed [OW:0]   p_d [3];
  logic [OW-1:0]        um  [3];
  axis_e                axis;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_d[i] = (OW+1)'(u[i]) + (OW+1)'(v[i]);
      um[i]  = u[i][OW-1] ? OW'(-u[i]) : OW'(u[i]);
    end
    if (um[0] < um[1]) begin
      axis = (um[0] < um[2]) ? AX_X : AX_Z;
    end else begin
      axis = (um[1] < um[2]) ? AX_Y : AX_Z;
    end
    case (axis)
      AX_X: begin
        p_d[0] = '0;
        p_d[1] = (OW+1)'(u[2]);
        p_d[2] = -(OW+1)'(u[1]);
      end
      AX_Y: begin
        p_d[0] = -(OW+1)'(u[2]);
        p_d[1] = '0;
        p_d[2] = (OW+1)'(u[0]);
      end
      default: begin
        p_d[0] = (OW+1)'(u[1]);
        p_d[1] = -(OW+1)'(u[0]);
        p_d[2] = '0;
      end
    endcase
  end

  logic                 t1_valid_q;
  logic signed [OW-1:0] u1_q [3];
  logic signed [OW:0]   s1_q [3];
  logic signed [OW:0]   p1_q [3];
  logic                 opp1_q;
  logic                 zero1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else if (en) begin
      t1_valid_q <= uv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q    <= u;
      s1_q    <= s_d;
      p1_q    <= p_d;
      opp1_q  <= (s_d[0] == '0) && (s_d[1] == '0) && (s_d[2] == '0);
      zero1_q <= !(nz_u && nz_v);
    end
  end

  // second normalization: half vector or fallback axis
  logic signed [NORM_IN_W-1:0] c3 [3];
  logic signed [OW-1:0]        h  [3];
  logic                        h_valid;
  logic                        h_nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c3[i] = opp1_q ? NORM_IN_W'(p1_q[i]) : NORM_IN_W'(s1_q[i]);
    end
  end

  saq_norm #(.OutFracBits(OutFracBits)) u_norm_h (
    .clk_i, .rst_ni, .en_i(en), .valid_i(t1_valid_q), .c_i(c3),
    .valid_o(h_valid), .nz_o(h_nz), .o_o(h)
  );

  // u and flags ride alongside the second normalizer
  logic [DW-1:0] dl_q [LAT];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= {u1_q[0], u1_q[1], u1_q[2], opp1_q, zero1_q};
      for (int k = 1; k < LAT; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  logic signed [OW-1:0] ud [3];
  logic                 opp_d;
  logic                 zero_d;
  assign {ud[0], ud[1], ud[2], opp_d, zero_d} = dl_q[LAT-1];

  // products
  logic                 pr_valid_q;
  logic signed [PW-1:0] pr_q [9];
  logic signed [OW-1:0] h2_q [3];
  logic                 opp2_q;
  logic                 zero2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0] <= ud[0] * h[0];
      pr_q[1] <= ud[1] * h[1];
      pr_q[2] <= ud[2] * h[2];
      pr_q[3] <= ud[1] * h[2];
      pr_q[4] <= ud[2] * h[1];
      pr_q[5] <= ud[2] * h[0];
      pr_q[6] <= ud[0] * h[2];
      pr_q[7] <= ud[0] * h[1];
      pr_q[8] <= ud[1] * h[0];
      h2_q    <= h;
      opp2_q  <= opp_d;
      zero2_q <= zero_d;
    end
  end

  // dot and cross sums
  logic                 sm_valid_q;
  logic signed [SW-1:0] sm_q [4];
  logic signed [OW-1:0] h3_q [3];
  logic                 opp3_q;
  logic                 zero3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q[0] <= SW'(pr_q[0]) + SW'(pr_q[1]) + SW'(pr_q[2]);
      sm_q[1] <= SW'(pr_q[3]) - SW'(pr_q[4]);
      sm_q[2] <= SW'(pr_q[5]) - SW'(pr_q[6]);
      sm_q[3] <= SW'(pr_q[7]) - SW'(pr_q[8]);
      h3_q    <= h2_q;
      opp3_q  <= opp2_q;
      zero3_q <= zero2_q;
    end
  end

  // round half away from zero, then clamp to the output range
  function automatic logic signed [Q_W-1:0] scale_sat(input logic signed [SW-1:0] s);
    logic [SW-1:0]        m;
    logic signed [SW-1:0] r;
    m = s[SW-1] ? SW'(-s) : SW'(s);
    m = (m + HalfLsb) >> OutFracBits;
    r = s[SW-1] ? -signed'(m) : signed'(m);
    if (r > QMax) begin
      scale_sat = Q_W'(QMax);
    end else if (r < QMin) begin
      scale_sat = Q_W'(QMin);
    end else begin
      scale_sat = Q_W'(r);
    end
  endfunction

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_valid_q  <= 1'b0;
      sm_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      pr_valid_q  <= h_valid;
      sm_valid_q  <= pr_valid_q;
      out_valid_q <= sm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (opp3_q) begin
        quat_w_o <= '0;
        quat_x_o <= Q_W'(h3_q[0]);
        quat_y_o <= Q_W'(h3_q[1]);
        quat_z_o <= Q_W'(h3_q[2]);
      end else begin
        quat_w_o <= scale_sat(sm_q[0]);
        quat_x_o <= scale_sat(sm_q[1]);
        quat_y_o <= scale_sat(sm_q[2]);
        quat_z_o <= scale_sat(sm_q[3]);
      end
      opposite_case_o <= opp3_q;
      zero_input_o    <= zero3_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  localparam logic signed [OW-1:0]  HalfUnit = OW'(1) << (OutFracBits - 1);
  localparam logic signed [Q_W-1:0] HalfQ = Q_W'(1) << (OutFracBits - 1);

  // a nonzero normalized vector keeps its largest part above one half
  a_unit_h: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_valid && h_nz |->
      (h[0] >= HalfUnit || h[0] <= -HalfUnit || h[1] >= HalfUnit ||
       h[1] <= -HalfUnit || h[2] >= HalfUnit || h[2] <= -HalfUnit))
    else $error("normalized half vector too short");

  // both inputs zero gives an all-zero quaternion
  a_both_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && opposite_case_o && zero_input_o |->
      quat_w_o == '0 && quat_x_o == '0 && quat_y_o == '0 && quat_z_o == '0)
    else $error("zero pair gave nonzero quaternion");

  // a true opposite pair gives a unit axis
  a_opp_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && opposite_case_o && !zero_input_o |->
      (quat_x_o >= HalfQ || quat_x_o <= -HalfQ || quat_y_o >= HalfQ ||
       quat_y_o <= -HalfQ || quat_z_o >= HalfQ || quat_z_o <= -HalfQ))
    else $error("opposite pair gave degenerate axis");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench: shortest-arc quaternion block checked against a bit-exact predictor
module testbench;
  import saq_pkg::*;

  localparam int OFB = OUT_FRAC_BITS_DEF;
  localparam int LAT = 2 * OFB + 83;
  localparam int N_RANDOM = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;

  typedef longint vec3_t[3];
  typedef logic signed [IN_W-1:0] comp_t;

  typedef struct {
    logic signed [Q_W-1:0] w, x, y, z;
    logic opp, zin;
  } quat_t;

  typedef struct {
    comp_t ax, ay, az, bx, by, bz;
    bit    typed;
    quat_t q;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  comp_t first_x_i = '0, first_y_i = '0, first_z_i = '0;
  comp_t second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [Q_W-1:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic opposite_case_o, zero_input_o;

  shortest_arc_quaternion dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quat_t pending_quats[$];
  int errors = 0;
  int n_results = 0, n_opp = 0, n_zero = 0;
  int idle_mode = 0;   // 0: sender 23 / receiver 67, 1: swapped, 2: no idling
  bit hold_req = 0;
  longint cycles = 0;

  // ---------------- predictor ----------------
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit to_unit(input vec3_t c, output vec3_t o);
    longint unsigned a[3], m = 0, sum = 0, len, qq;
    for (int i = 0; i < 3; i++) begin
      a[i] = c[i] < 0 ? -c[i] : c[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 0;
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += a[i] * a[i];
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      qq = ((a[i] << OFB) + (len >> 1)) / len;
      o[i] = c[i] < 0 ? -longint'(qq) : longint'(qq);
    end
    return 1;
  endfunction

  function automatic longint round_down(longint s);
    longint unsigned half = 64'd1 << (OFB - 1);
    if (s < 0) return -longint'((unsigned'(-s) + half) >> OFB);
    return longint'((unsigned'(s) + half) >> OFB);
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[Q_W-1:0];
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic quat_t arc_quat(row_t r);
    vec3_t a, b, u, v, p, n, s, h;
    longint q[4], mx, my, mz;
    bit nzu, nzv, opp;
    quat_t res;
    a = '{longint'(r.ax), longint'(r.ay), longint'(r.az)};
    b = '{longint'(r.bx), longint'(r.by), longint'(r.bz)};
    nzu = to_unit(a, u);
    nzv = to_unit(b, v);
    opp = (u[0] == -v[0]) && (u[1] == -v[1]) && (u[2] == -v[2]);
    if (opp) begin
      mx = absl(u[0]); my = absl(u[1]); mz = absl(u[2]);
      // cross with the axis of the smallest component, strict compares
      if (mx < my ? mx < mz : 1'b0) p = '{0, u[2], -u[1]};
      else if (!(mx < my) && my < mz) p = '{-u[2], 0, u[0]};
      else p = '{u[1], -u[0], 0};
      void'(to_unit(p, n));
      q = '{0, n[0], n[1], n[2]};
    end else begin
      for (int i = 0; i < 3; i++) s[i] = u[i] + v[i];
      void'(to_unit(s, h));
      q[0] = round_down(u[0] * h[0] + u[1] * h[1] + u[2] * h[2]);
      q[1] = round_down(u[1] * h[2] - u[2] * h[1]);
      q[2] = round_down(u[2] * h[0] - u[0] * h[2]);
      q[3] = round_down(u[0] * h[1] - u[1] * h[0]);
    end
    res.w = sat32(q[0]); res.x = sat32(q[1]);
    res.y = sat32(q[2]); res.z = sat32(q[3]);
    res.opp = opp;
    res.zin = !nzu || !nzv;
    return res;
  endfunction

  // ---------------- stimulus ----------------
  function automatic row_t plain(comp_t ax, ay, az, bx, by, bz);
    row_t r;
    r = '{ax, ay, az, bx, by, bz, 1'b0, '{0, 0, 0, 0, 0, 0}};
    return r;
  endfunction

  function automatic row_t known(comp_t ax, ay, az, bx, by, bz, quat_t q);
    row_t r = plain(ax, ay, az, bx, by, bz);
    r.typed = 1'b1;
    r.q = q;
    return r;
  endfunction

  function automatic comp_t rnd_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 255) - 128;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $urandom_range(0, 2) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t rnd_row();
    row_t r;
    int kind = $urandom_range(0, 9);
    r = plain(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
    case (kind)
      0: begin r.bx = -r.ax; r.by = -r.ay; r.bz = -r.az; end    // antiparallel
      1: begin   // antiparallel at twice the length
        r.ax = $signed($urandom) >>> 2; r.ay = $signed($urandom) >>> 2;
        r.az = $signed($urandom) >>> 2;
        r.bx = -(r.ax <<< 1); r.by = -(r.ay <<< 1); r.bz = -(r.az <<< 1);
      end
      2: begin r.bx = r.ax; r.by = r.ay; r.bz = r.az; end       // parallel
      3: begin
        if ($urandom_range(0, 1)) begin r.ax = 0; r.ay = 0; r.az = 0; end
        else begin r.bx = 0; r.by = 0; r.bz = 0; end
      end
      4: begin   // single axis antiparallel, exercises axis ties
        r = plain(0, 0, 0, 0, 0, 0);
        case ($urandom_range(0, 2))
          0: begin r.ax = $urandom_range(1, 1000); r.bx = -$urandom_range(1, 1000); end
          1: begin r.ay = -$urandom_range(1, 1000); r.by = $urandom_range(1, 1000); end
          default: begin r.az = $urandom_range(1, 1000); r.bz = -$urandom_range(1, 1000); end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  row_t directed[$];

  initial begin
    localparam logic signed [31:0] ONE = 32'sd1 << OFB;
    directed.push_back(known(0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 1, 1}));
    directed.push_back(known(0, 0, 0, 5, 0, 0, '{0, 0, 0, 0, 0, 1}));
    directed.push_back(known(1, 0, 0, 0, 0, 0, '{ONE, 0, 0, 0, 0, 1}));
    directed.push_back(known(1, 0, 0, 1, 0, 0, '{ONE, 0, 0, 0, 0, 0}));
    directed.push_back(known(1, 0, 0, -1, 0, 0, '{0, 0, -ONE, 0, 1, 0}));
    directed.push_back(known(0, 0, 7, 0, 0, 7, '{ONE, 0, 0, 0, 0, 0}));
    directed.push_back(plain(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                             32'sh80000000, 32'sh80000000, 32'sh80000000));
    directed.push_back(plain(32'sh80000000, 32'sh80000000, 32'sh80000000,
                             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    directed.push_back(plain(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0));
    directed.push_back(plain(32'sh80000000, 0, 0, 32'sh80000000, 0, 0));
    directed.push_back(plain(1, 1, 1, -1, -1, -1));
    directed.push_back(plain(1, 1, 0, -1, -1, 0));
    directed.push_back(plain(0, 1, 1, 0, -1, -1));
    directed.push_back(plain(3, -3, 2, -3, 3, -2));
    directed.push_back(plain(1, 0, 0, 0, 1, 0));
    directed.push_back(plain(-1, -1, -1, 32'sh7fffffff, 1, -1));
    directed.push_back(plain(32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0));
    directed.push_back(plain(1, 2, 3, 1, 2, 3));
    directed.push_back(plain(-65536, 65536, 0, 0, 0, 0));
    directed.push_back(plain(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
                             32'shf0f0f0f0, 32'sh33333333, 32'shcccccccc));
  end

  // sender: accept check at rising edge, payload changes at falling edge
  task automatic send_beat(row_t r);
    quat_t e;
    @(negedge clk_i);
    while (idle_mode != 2 && $urandom_range(0, 99) < (idle_mode == 0 ? 23 : 67)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_x_i <= r.ax; first_y_i <= r.ay; first_z_i <= r.az;
    second_x_i <= r.bx; second_y_i <= r.by; second_z_i <= r.bz;
    do @(posedge clk_i); while (in_stall_o);
    e = r.typed ? r.q : arc_quat(r);
    pending_quats.push_back(e);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_beat(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_mode = (i < N_RANDOM / 3) ? 0 : (i < 2 * N_RANDOM / 3) ? 1 : 2;
      if (i == N_RANDOM / 2) hold_req = 1;
      send_beat(rnd_row());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk_i);
    repeat (LAT + 20) @(posedge clk_i);
    $display("covered %0d results: %0d antiparallel, %0d with a zero vector",
             n_results, n_opp, n_zero);
    $display("with sender and receiver gaps and one long receiver hold-off");
    if (errors == 0 && pending_quats.size() == 0) begin
      $display("[shortest_arc_quaternion] OK");
    end else begin
      $display("[shortest_arc_quaternion] ERROR");
    end
    $finish;
  end

  // receiver stall, with one long hold-off so the pipeline backs up
  initial begin
    int held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && held < HOLD_CYCLES) begin
        held++;
        out_stall_i <= 1'b1;
      end else if (idle_mode == 2) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= $urandom_range(0, 99) < (idle_mode == 0 ? 67 : 23);
      end
    end
  end

  // result checking
  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_quats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_quats.pop_front();
        n_results++;
        if (opposite_case_o) n_opp++;
        if (zero_input_o) n_zero++;
        if (quat_w_o !== e.w) begin
          $error("quat_w exp %0d got %0d", e.w, quat_w_o); errors++;
        end
        if (quat_x_o !== e.x) begin
          $error("quat_x exp %0d got %0d", e.x, quat_x_o); errors++;
        end
        if (quat_y_o !== e.y) begin
          $error("quat_y exp %0d got %0d", e.y, quat_y_o); errors++;
        end
        if (quat_z_o !== e.z) begin
          $error("quat_z exp %0d got %0d", e.z, quat_z_o); errors++;
        end
        if (opposite_case_o !== e.opp) begin
          $error("opposite_case exp %0d got %0d", e.opp, opposite_case_o); errors++;
        end
        if (zero_input_o !== e.zin) begin
          $error("zero_input exp %0d got %0d", e.zin, zero_input_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[shortest_arc_quaternion] ERROR");
      $finish;
    end
  end

endmodule

FILE: shortest_arc_quaternion.f
src/saq_pkg.sv
src/saq_norm.sv
src/shortest_arc_quaternion.sv
test/testbench.sv
